@@ rtl/qte_pkg.sv @@
// Shared widths, constants and helper functions for the quaternion to Euler angle pipeline.
// No dependencies; every rtl module imports this package.
`default_nettype none
package qte_pkg;

	// CORDIC vector width and angle width (radians in units of 2^-24)
	localparam int CW = 36;
	localparam int ZW = 29;
	// Divider operand width and quotient bits
	localparam int NW = 33;
	localparam int QB = 31;
	// Square root radicand width and root bits
	localparam int RW = 62;
	localparam int CB = 31;
	// Arctangent table length and scaling product width
	localparam int ATAN_LEN = 24;
	localparam int PW = 51;

	localparam logic signed [ZW-1:0] PI_Q24 = 29'sd52707179;
	localparam logic signed [22:0] DEG_MUL = 23'sd1877468;
	localparam logic signed [PW-1:0] DEG_RND = PW'(64'sd2147483648);
	localparam logic signed [PW-1:0] RAD_RND = PW'(1024);
	localparam logic signed [PW-1:0] SAT_MAX = PW'(32767);
	localparam logic signed [PW-1:0] SAT_MIN = PW'(-32768);
	localparam logic [QB-1:0] ONE_Q30 = {1'b1, {(QB-1){1'b0}}};
	localparam logic [RW-1:0] ONE_Q60 = RW'(1) << (2 * (CB - 1));

	// Side data that rides along the divider
	typedef struct packed {
		logic                 nz;
		logic                 neg;
		logic signed [CW-1:0] yaw_y;
		logic signed [CW-1:0] yaw_x;
		logic signed [CW-1:0] roll_y;
		logic signed [CW-1:0] roll_x;
	} div_tag_t;

	// Side data that rides along the square root
	typedef struct packed {
		logic                 nz;
		logic signed [CW-1:0] s;
		logic signed [CW-1:0] yaw_y;
		logic signed [CW-1:0] yaw_x;
		logic signed [CW-1:0] roll_y;
		logic signed [CW-1:0] roll_x;
	} sqr_tag_t;

	// round(atan(2^-i) * 2^24)
	function automatic logic signed [ZW-1:0] atan_q24(input int idx);
		logic signed [ZW-1:0] a;
		case (idx)
			0:  a = 29'sd13176795;
			1:  a = 29'sd7778716;
			2:  a = 29'sd4110060;
			3:  a = 29'sd2086331;
			4:  a = 29'sd1047214;
			5:  a = 29'sd524117;
			6:  a = 29'sd262123;
			7:  a = 29'sd131069;
			8:  a = 29'sd65536;
			9:  a = 29'sd32768;
			10: a = 29'sd16384;
			11: a = 29'sd8192;
			12: a = 29'sd4096;
			13: a = 29'sd2048;
			14: a = 29'sd1024;
			15: a = 29'sd512;
			16: a = 29'sd256;
			17: a = 29'sd128;
			18: a = 29'sd64;
			19: a = 29'sd32;
			20: a = 29'sd16;
			21: a = 29'sd8;
			22: a = 29'sd4;
			23: a = 29'sd2;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Clamp to the 16-bit signed range
	function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
		logic signed [15:0] r;
		if (v > SAT_MAX) begin
			r = 16'sh7FFF;
		end else if (v < SAT_MIN) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Scale an angle to radians Q2.13 or 1/128 degree units
	function automatic logic signed [15:0] scale_angle(input logic signed [ZW-1:0] z,
		input logic signed [PW-1:0] p, input logic deg);
		logic signed [PW-1:0] v;
		if (deg) begin
			v = (p + DEG_RND) >>> 32;
		end else begin
			v = (PW'(z) + RAD_RND) >>> 11;
		end
		return sat16(v);
	endfunction

endpackage
`default_nettype wire

@@ rtl/qte_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, quotient = num * 2^30 / norm.
// Depends on qte_pkg for operand widths.
`default_nettype none
module qte_div #(
	parameter int TW = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_v,
	input  wire logic [qte_pkg::NW-1:0]  num_abs,
	input  wire logic [qte_pkg::NW-1:0]  norm,
	input  wire logic [TW-1:0]           in_tag,
	output logic                         out_v,
	output logic [qte_pkg::QB-1:0]       quo,
	output logic [TW-1:0]                out_tag
);
	import qte_pkg::*;

	logic [NW-1:0] rem_s  [0:QB-1];
	logic [NW-1:0] den_s  [0:QB-1];
	logic [QB-1:0] quo_s  [0:QB-1];
	logic [TW-1:0] tag_s  [0:QB-1];
	logic          v_s    [0:QB-1];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [NW:0]   trial;
		logic [NW:0]   diff;
		logic [NW-1:0] den_i;
		logic [QB-1:0] quo_i;
		logic [TW-1:0] tag_i;
		logic          v_i;
		logic          ge;

		// Pick this stage's source: the inputs or the previous stage
		if (k == 0) begin : g_first
			assign trial = {1'b0, num_abs};
			assign den_i = norm;
			assign quo_i = '0;
			assign tag_i = in_tag;
			assign v_i   = in_v;
		end else begin : g_next
			assign trial = {rem_s[k-1], 1'b0};
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
			assign tag_i = tag_s[k-1];
			assign v_i   = v_s[k-1];
		end

		// Trial subtract decides one quotient bit
		assign diff = trial - {1'b0, den_i};
		assign ge   = (trial >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[NW-1:0] : trial[NW-1:0];
				den_s[k] <= den_i;
				quo_s[k] <= {quo_i[QB-2:0], ge};
				tag_s[k] <= tag_i;
			end
		end
	end

	assign out_v   = v_s[QB-1];
	assign quo     = quo_s[QB-1];
	assign out_tag = tag_s[QB-1];

endmodule
`default_nettype wire

@@ rtl/qte_isqrt.sv @@
// Pipelined integer square root: two radicand bits per stage, floor(sqrt(rad)).
// Depends on qte_pkg for widths.
`default_nettype none
module qte_isqrt #(
	parameter int TW = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_v,
	input  wire logic [qte_pkg::RW-1:0]  rad,
	input  wire logic [TW-1:0]           in_tag,
	output logic                         out_v,
	output logic [qte_pkg::CB-1:0]       root,
	output logic [TW-1:0]                out_tag
);
	import qte_pkg::*;

	logic [RW-1:0] val_s [0:CB-1];
	logic [RW-1:0] res_s [0:CB-1];
	logic [TW-1:0] tag_s [0:CB-1];
	logic          v_s   [0:CB-1];

	for (genvar j = 0; j < CB; j++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (CB - 1 - j));
		logic [RW-1:0] val_i;
		logic [RW-1:0] res_i;
		logic [RW-1:0] sum;
		logic [TW-1:0] tag_i;
		logic          v_i;
		logic          ge;

		if (j == 0) begin : g_first
			assign val_i = rad;
			assign res_i = '0;
			assign tag_i = in_tag;
			assign v_i   = in_v;
		end else begin : g_next
			assign val_i = val_s[j-1];
			assign res_i = res_s[j-1];
			assign tag_i = tag_s[j-1];
			assign v_i   = v_s[j-1];
		end

		assign sum = res_i + BIT;
		assign ge  = (val_i >= sum);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_i;
			end
		end

		// Subtract and set the root bit, or just shift
		always_ff @(posedge clk) begin
			if (en) begin
				val_s[j] <= ge ? (val_i - sum) : val_i;
				res_s[j] <= ge ? ((res_i >> 1) + BIT) : (res_i >> 1);
				tag_s[j] <= tag_i;
			end
		end
	end

	assign out_v   = v_s[CB-1];
	assign root    = res_s[CB-1][CB-1:0];
	assign out_tag = tag_s[CB-1];

endmodule
`default_nettype wire

@@ rtl/qte_cordic.sv @@
// Pipelined vectoring CORDIC: atan2(y, x) in radians, units of 2^-24, one step per stage.
// Depends on qte_pkg for widths and the arctangent table.
`default_nettype none
module qte_cordic #(
	parameter int STEPS = 16,
	parameter int TW    = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_v,
	input  wire logic signed [qte_pkg::CW-1:0]  x_in,
	input  wire logic signed [qte_pkg::CW-1:0]  y_in,
	input  wire logic [TW-1:0]                  in_tag,
	output logic                                out_v,
	output logic signed [qte_pkg::ZW-1:0]       z_out,
	output logic [TW-1:0]                       out_tag
);
	import qte_pkg::*;

	localparam int NS = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

	logic signed [CW-1:0] x_p, y_p;
	logic signed [ZW-1:0] z_p;
	logic                 zero_p, v_p;
	logic [TW-1:0]        tag_p;

	logic signed [CW-1:0] x_s    [0:NS-1];
	logic signed [CW-1:0] y_s    [0:NS-1];
	logic signed [ZW-1:0] z_s    [0:NS-1];
	logic                 zero_s [0:NS-1];
	logic [TW-1:0]        tag_s  [0:NS-1];
	logic                 v_s    [0:NS-1];

	// Fold the left half plane over by pi
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_p <= (x_in == '0) && (y_in == '0);
			tag_p  <= in_tag;
			if (x_in < 0) begin
				x_p <= -x_in;
				y_p <= -y_in;
				z_p <= (y_in >= 0) ? PI_Q24 : -PI_Q24;
			end else begin
				x_p <= x_in;
				y_p <= y_in;
				z_p <= '0;
			end
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic signed [CW-1:0] x_i, y_i;
		logic signed [ZW-1:0] z_i;
		logic                 zero_i, v_i;
		logic [TW-1:0]        tag_i;

		if (i == 0) begin : g_first
			assign x_i    = x_p;
			assign y_i    = y_p;
			assign z_i    = z_p;
			assign zero_i = zero_p;
			assign tag_i  = tag_p;
			assign v_i    = v_p;
		end else begin : g_next
			assign x_i    = x_s[i-1];
			assign y_i    = y_s[i-1];
			assign z_i    = z_s[i-1];
			assign zero_i = zero_s[i-1];
			assign tag_i  = tag_s[i-1];
			assign v_i    = v_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i;
			end
		end

		// Rotate toward the x axis and accumulate the angle
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i] <= zero_i;
				tag_s[i]  <= tag_i;
				if (y_i >= 0) begin
					x_s[i] <= x_i + (y_i >>> i);
					y_s[i] <= y_i - (x_i >>> i);
					z_s[i] <= z_i + atan_q24(i);
				end else begin
					x_s[i] <= x_i - (y_i >>> i);
					y_s[i] <= y_i + (x_i >>> i);
					z_s[i] <= z_i - atan_q24(i);
				end
			end
		end
	end

	assign out_v   = v_s[NS-1];
	assign z_out   = zero_s[NS-1] ? '0 : z_s[NS-1];
	assign out_tag = tag_s[NS-1];

endmodule
`default_nettype wire

@@ rtl/quaternion_to_euler_angles_top.sv @@
// Top level: quaternion to yaw, pitch and roll through products, divider, square root and CORDIC.
// Depends on qte_pkg, qte_div, qte_isqrt and qte_cordic.
//
//   channel   signals                                   direction
//   request   in_valid/in_ready, quat_real..quat_k      in
//   result    out_valid/out_ready, yaw/pitch/roll,      out
//             norm_zero
//   config    cfg_we, cfg_wdata (angle_in_degrees)      in
//
// One request enters per cycle while the output is not held; the path runs through the
// 31-stage divider, the 31-stage square root and the CORDIC steps.
// Reset clears all valid bits and sets degree output mode.
// A stall freezes every stage at once; the output register holds its result until taken.
`default_nettype none
module quaternion_to_euler_angles_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] quat_real,
	input  wire logic signed [15:0] quat_i,
	input  wire logic signed [15:0] quat_j,
	input  wire logic signed [15:0] quat_k,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      yaw_angle,
	output logic signed [15:0]      pitch_angle,
	output logic signed [15:0]      roll_angle,
	output logic                    norm_zero,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata
);
	import qte_pkg::*;

	logic en;
	logic deg_q;
	logic out_valid_q;

	// Advance the whole pipe unless the output is held
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Output unit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b1;
		end else if (cfg_we) begin
			deg_q <= cfg_wdata;
		end
	end

	// Stage 1: products of the components
	logic signed [31:0] rr_s1, ii_s1, jj_s1, kk_s1, ij_s1, kr_s1, jk_s1, ir_s1, jr_s1, ik_s1;
	logic               v_s1;

	// Stage 2: arctangent arguments, pitch numerator and squared norm
	logic signed [CW-1:0] yaw_y_s2, yaw_x_s2, roll_y_s2, roll_x_s2, num_s2;
	logic [NW-1:0]        norm_s2;
	logic                 v_s2;

	// Stage 3: numerator magnitude and sign, zero-norm flag
	logic signed [CW-1:0] yaw_y_s3, yaw_x_s3, roll_y_s3, roll_x_s3;
	logic [NW-1:0]        abs_s3, norm_s3;
	logic                 neg_s3, nz_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1 <= quat_real * quat_real;
			ii_s1 <= quat_i * quat_i;
			jj_s1 <= quat_j * quat_j;
			kk_s1 <= quat_k * quat_k;
			ij_s1 <= quat_i * quat_j;
			kr_s1 <= quat_k * quat_real;
			jk_s1 <= quat_j * quat_k;
			ir_s1 <= quat_i * quat_real;
			jr_s1 <= quat_j * quat_real;
			ik_s1 <= quat_i * quat_k;

			yaw_y_s2  <= (CW'(ij_s1) + CW'(kr_s1)) <<< 1;
			yaw_x_s2  <= CW'(rr_s1) + CW'(ii_s1) - CW'(jj_s1) - CW'(kk_s1);
			roll_y_s2 <= (CW'(jk_s1) + CW'(ir_s1)) <<< 1;
			roll_x_s2 <= CW'(rr_s1) - CW'(ii_s1) - CW'(jj_s1) + CW'(kk_s1);
			num_s2    <= (CW'(jr_s1) - CW'(ik_s1)) <<< 1;
			norm_s2   <= NW'(rr_s1) + NW'(ii_s1) + NW'(jj_s1) + NW'(kk_s1);

			yaw_y_s3  <= yaw_y_s2;
			yaw_x_s3  <= yaw_x_s2;
			roll_y_s3 <= roll_y_s2;
			roll_x_s3 <= roll_x_s2;
			neg_s3    <= (num_s2 < 0);
			abs_s3    <= (num_s2 < 0) ? NW'(-num_s2) : NW'(num_s2);
			norm_s3   <= norm_s2;
			nz_s3     <= (norm_s2 == '0);
		end
	end

	// Divide the numerator by the norm
	div_tag_t      div_in_tag, div_out_tag;
	logic          div_v;
	logic [QB-1:0] quo;

	assign div_in_tag = '{nz: nz_s3, neg: neg_s3, yaw_y: yaw_y_s3, yaw_x: yaw_x_s3,
		roll_y: roll_y_s3, roll_x: roll_x_s3};

	qte_div #(
		.TW($bits(div_tag_t))
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s3),
		.num_abs (abs_s3),
		.norm    (norm_s3),
		.in_tag  (div_in_tag),
		.out_v   (div_v),
		.quo     (quo),
		.out_tag (div_out_tag)
	);

	// Stage 4: clamp the sine and square it
	logic [QB-1:0] mag_c;
	logic [QB-1:0] mag_s4;
	logic [RW-1:0] sq_s4;
	div_tag_t      tag_s4;
	logic          v_s4;

	// Stage 5: radicand for the cosine and signed sine
	logic [RW-1:0] rad_s5;
	sqr_tag_t      tag_s5;
	logic          v_s5;

	assign mag_c = (quo > ONE_Q30) ? ONE_Q30 : quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= div_v;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4 <= mag_c;
			sq_s4  <= RW'(mag_c) * RW'(mag_c);
			tag_s4 <= div_out_tag;

			rad_s5        <= ONE_Q60 - sq_s4;
			tag_s5.nz     <= tag_s4.nz;
			tag_s5.s      <= tag_s4.neg ? -CW'(mag_s4) : CW'(mag_s4);
			tag_s5.yaw_y  <= tag_s4.yaw_y;
			tag_s5.yaw_x  <= tag_s4.yaw_x;
			tag_s5.roll_y <= tag_s4.roll_y;
			tag_s5.roll_x <= tag_s4.roll_x;
		end
	end

	// Cosine of the pitch
	sqr_tag_t      sqr_tag;
	logic          sqr_v;
	logic [CB-1:0] root;

	qte_isqrt #(
		.TW($bits(sqr_tag_t))
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s5),
		.rad     (rad_s5),
		.in_tag  (tag_s5),
		.out_v   (sqr_v),
		.root    (root),
		.out_tag (sqr_tag)
	);

	// Three arctangents side by side; the yaw lane carries valid and the zero flag
	logic signed [ZW-1:0] yaw_z, pitch_z, roll_z;
	logic                 cor_v, cor_nz;

	qte_cordic #(
		.STEPS (CORDIC_STEPS),
		.TW    (1)
	) u_cordic_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (sqr_v),
		.x_in    (sqr_tag.yaw_x),
		.y_in    (sqr_tag.yaw_y),
		.in_tag  (sqr_tag.nz),
		.out_v   (cor_v),
		.z_out   (yaw_z),
		.out_tag (cor_nz)
	);

	qte_cordic #(
		.STEPS (CORDIC_STEPS),
		.TW    (1)
	) u_cordic_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (sqr_v),
		.x_in    (CW'(root)),
		.y_in    (sqr_tag.s),
		.in_tag  (1'b0),
		.out_v   (),
		.z_out   (pitch_z),
		.out_tag ()
	);

	qte_cordic #(
		.STEPS (CORDIC_STEPS),
		.TW    (1)
	) u_cordic_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (sqr_v),
		.x_in    (sqr_tag.roll_x),
		.y_in    (sqr_tag.roll_y),
		.in_tag  (1'b0),
		.out_v   (),
		.z_out   (roll_z),
		.out_tag ()
	);

	// Stage 6: degree products
	logic signed [ZW-1:0] yaw_z_s6, pitch_z_s6, roll_z_s6;
	logic signed [PW-1:0] yaw_p_s6, pitch_p_s6, roll_p_s6;
	logic                 nz_s6, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s6        <= cor_v;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_z_s6   <= yaw_z;
			pitch_z_s6 <= pitch_z;
			roll_z_s6  <= roll_z;
			yaw_p_s6   <= PW'(yaw_z) * PW'(DEG_MUL);
			pitch_p_s6 <= PW'(pitch_z) * PW'(DEG_MUL);
			roll_p_s6  <= PW'(roll_z) * PW'(DEG_MUL);
			nz_s6      <= cor_nz;
		end
	end

	// Output register: round, saturate, zero the angles for a null quaternion
	logic signed [15:0] yaw_q, pitch_q, roll_q;
	logic               nz_q;

	always_ff @(posedge clk) begin
		if (en) begin
			nz_q    <= nz_s6;
			yaw_q   <= nz_s6 ? '0 : scale_angle(yaw_z_s6, yaw_p_s6, deg_q);
			pitch_q <= nz_s6 ? '0 : scale_angle(pitch_z_s6, pitch_p_s6, deg_q);
			roll_q  <= nz_s6 ? '0 : scale_angle(roll_z_s6, roll_p_s6, deg_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign yaw_angle   = yaw_q;
	assign pitch_angle = pitch_q;
	assign roll_angle  = roll_q;
	assign norm_zero   = nz_q;

endmodule
`default_nettype wire
